// File: hdl/ppsf_pkg.sv
// Shared widths, register codes, quantity codes and the CORDIC angle table.
package ppsf_pkg;

  localparam int DATA_W        = 32;
  localparam int NUM_FIELDS    = 7;
  localparam int CFG_IDX_W     = 4;
  localparam int CFG_DATA_W    = 64;
  localparam int MASS_W        = 31;
  localparam int SELECT_W      = 30;
  localparam int SLOT_FIELD_W  = 5;

  localparam int CORDIC_ITERS  = 24;
  localparam int CORDIC_W      = 60;
  localparam int ANGLE_W       = 35;
  localparam int PRESCALE_BITS = 24;
  localparam int ANGLE_FRAC    = 24;

  localparam logic [CFG_IDX_W-1:0] REG_MASS    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SELECT  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOUNDS0 = 4'd2;

  typedef enum logic [3:0] {
    QTY_POS_X,
    QTY_POS_Y,
    QTY_POS_Z,
    QTY_MOM_X,
    QTY_MOM_Y,
    QTY_MOM_Z,
    QTY_MOM_TOT,
    QTY_KIN_EN,
    QTY_AZIMUTH,
    QTY_POLAR
  } qty_e;

  localparam logic signed [ANGLE_W-1:0] DEG180_Q24 = 35'sd3019898880;

  // atan(2^-i) in degrees, Q24
  localparam logic signed [ANGLE_W-1:0] ATAN_DEG_Q24 [CORDIC_ITERS] = '{
    35'sd754974720, 35'sd445687602, 35'sd235489088, 35'sd119537938,
    35'sd60000934,  35'sd30029717,  35'sd15018523,  35'sd7509720,
    35'sd3754917,   35'sd1877466,   35'sd938734,    35'sd469367,
    35'sd234684,    35'sd117342,    35'sd58671,     35'sd29335,
    35'sd14668,     35'sd7334,      35'sd3667,      35'sd1833,
    35'sd917,       35'sd458,       35'sd229,       35'sd115
  };

endpackage

// File: hdl/ppsf_delay.sv
// Fixed-depth shift line that keeps payload aligned with the arithmetic stages.
module ppsf_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] tap_q [DEPTH];

  always_ff @(posedge clk_i) begin
    tap_q[0] <= d_i;
    for (int i = 1; i < DEPTH; i++) begin
      tap_q[i] <= tap_q[i-1];
    end
  end

  assign q_o = tap_q[DEPTH-1];

endmodule

// File: hdl/ppsf_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module ppsf_isqrt import ppsf_pkg::*; (
  input  logic                  clk_i,
  input  logic [2*DATA_W-1:0]   rad_i,
  output logic [DATA_W-1:0]     root_o
);

  localparam int REM_W = DATA_W + 2;

  logic [REM_W-1:0]    rem_q  [DATA_W];
  logic [DATA_W-1:0]   root_q [DATA_W];
  logic [2*DATA_W-1:0] rad_q  [DATA_W];

  for (genvar k = 0; k < DATA_W; k++) begin : g_step
    logic [REM_W-1:0]    rem_in;
    logic [DATA_W-1:0]   root_in;
    logic [2*DATA_W-1:0] rad_in;
    logic [REM_W+1:0]    rem_sh;
    logic [REM_W+1:0]    trial;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
    end

    // bring down the next two radicand bits and try root*4+1
    assign rem_sh = {rem_in, rad_in[2*DATA_W-1 -: 2]};
    assign trial  = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      rad_q[k] <= rad_in << 2;
      if (rem_sh >= trial) begin
        rem_q[k]  <= REM_W'(rem_sh - trial);
        root_q[k] <= {root_in[DATA_W-2:0], 1'b1};
      end else begin
        rem_q[k]  <= REM_W'(rem_sh);
        root_q[k] <= {root_in[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign root_o = root_q[DATA_W-1];

endmodule

// File: hdl/ppsf_cordic.sv
// Pipelined vectoring CORDIC: atan2(y, x) in degrees, rounded to the output format.
module ppsf_cordic import ppsf_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk_i,
  input  logic signed [DATA_W:0]   x_i,
  input  logic signed [DATA_W-1:0] y_i,
  output logic signed [DATA_W-1:0] angle_o
);

  localparam logic signed [ANGLE_W-1:0] ZMAX = ANGLE_W'(64'sd2147483647);
  localparam logic signed [ANGLE_W-1:0] ZMIN = -ANGLE_W'(64'sd2147483648);

  logic signed [CORDIC_W-1:0] x_q    [CORDIC_ITERS+1];
  logic signed [CORDIC_W-1:0] y_q    [CORDIC_ITERS+1];
  logic signed [ANGLE_W-1:0]  z_q    [CORDIC_ITERS+1];
  logic                       zero_q [CORDIC_ITERS+1];

  logic signed [CORDIC_W-1:0] x_s;
  logic signed [CORDIC_W-1:0] y_s;
  logic signed [ANGLE_W-1:0]  z_r;
  logic signed [DATA_W-1:0]   angle_q;

  assign x_s = CORDIC_W'(x_i) <<< PRESCALE_BITS;
  assign y_s = CORDIC_W'(y_i) <<< PRESCALE_BITS;

  // fold the left half-plane onto the right, starting from +/-180
  always_ff @(posedge clk_i) begin
    zero_q[0] <= (x_i == '0) && (y_i == '0);
    if (x_i < 0) begin
      x_q[0] <= -x_s;
      y_q[0] <= -y_s;
      z_q[0] <= (y_i >= 0) ? DEG180_Q24 : -DEG180_Q24;
    end else begin
      x_q[0] <= x_s;
      y_q[0] <= y_s;
      z_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
    always_ff @(posedge clk_i) begin
      zero_q[i+1] <= zero_q[i];
      if (y_q[i] > 0) begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + ATAN_DEG_Q24[i];
      end else begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - ATAN_DEG_Q24[i];
      end
    end
  end

  if (FRAC_BITS < ANGLE_FRAC) begin : g_round
    localparam int SH = ANGLE_FRAC - FRAC_BITS;
    localparam logic signed [ANGLE_W-1:0] HALF = ANGLE_W'(64'sd1 <<< (SH - 1));
    assign z_r = (z_q[CORDIC_ITERS] + HALF) >>> SH;
  end else begin : g_keep
    assign z_r = z_q[CORDIC_ITERS];
  end

  always_ff @(posedge clk_i) begin
    if (zero_q[CORDIC_ITERS]) begin
      angle_q <= '0;
    end else if (z_r > ZMAX) begin
      angle_q <= ZMAX[DATA_W-1:0];
    end else if (z_r < ZMIN) begin
      angle_q <= ZMIN[DATA_W-1:0];
    end else begin
      angle_q <= z_r[DATA_W-1:0];
    end
  end

  assign angle_o = angle_q;

endmodule

// File: hdl/particle_phase_space_filter_core.sv
// Particle phase-space range filter: top level with derived quantities and slot compare.
//
// Input: one particle per transfer, taken at each rising edge with start high and
// busy low. busy is held low, so a particle can be started in every cycle.
// Output: a passing particle appears on the out_* ports for one cycle with
// out_valid_o high; a dropped particle gives nothing.
// Order is kept. The receiver cannot stall the block.
// Throughput is one particle per clock. The pipeline is made of the front
// end (squares and sums, 3 stages), the square-root pipeline (one stage per
// root bit, 32), the angle CORDIC (pre-fold, 24 iterations, rounding: 26)
// and the slot compare (1).
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (0 mass, 1 slot select, 2.. slot bounds) in the same edge; write only while
// no particle is in flight. Indices beyond the bounds of the present slots are
// ignored.
// Reset clears the registers, all slots disabled, and the in-flight valid bits.
module particle_phase_space_filter_core import ppsf_pkg::*; #(
  parameter int FRAC_BITS    = 16,
  parameter int FILTER_SLOTS = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [DATA_W-1:0]     pos_x_i,
  input  logic [DATA_W-1:0]     pos_y_i,
  input  logic [DATA_W-1:0]     pos_z_i,
  input  logic [DATA_W-1:0]     mom_x_i,
  input  logic [DATA_W-1:0]     mom_y_i,
  input  logic [DATA_W-1:0]     mom_z_i,
  input  logic [DATA_W-1:0]     part_weight_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output logic                  out_valid_o,
  output logic [DATA_W-1:0]     out_pos_x_o,
  output logic [DATA_W-1:0]     out_pos_y_o,
  output logic [DATA_W-1:0]     out_pos_z_o,
  output logic [DATA_W-1:0]     out_mom_x_o,
  output logic [DATA_W-1:0]     out_mom_y_o,
  output logic [DATA_W-1:0]     out_mom_z_o,
  output logic [DATA_W-1:0]     out_weight_o
);

  localparam int SQ_W       = 2 * DATA_W;
  localparam int PACK_W     = NUM_FIELDS * DATA_W;
  localparam int CORDIC_LAT = CORDIC_ITERS + 2;
  localparam int FRONT_LAT  = 3 + DATA_W;
  localparam int PIPE_DEPTH = FRONT_LAT + CORDIC_LAT;
  localparam int PROD_W     = MASS_W + DATA_W;

  localparam logic [SQ_W-1:0]   ONE_2F  = SQ_W'(1) << (2 * FRAC_BITS);
  localparam logic [DATA_W-1:0] ONE_F   = DATA_W'(1) << FRAC_BITS;
  localparam logic [DATA_W-1:0] SAT_POS = {1'b0, {(DATA_W-1){1'b1}}};

  // configuration registers
  logic [MASS_W-1:0]     mass_q;
  logic [SELECT_W-1:0]   select_q;
  logic [CFG_DATA_W-1:0] bounds_q [FILTER_SLOTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_q   <= '0;
      select_q <= '0;
      for (int k = 0; k < FILTER_SLOTS; k++) begin
        bounds_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_MASS) begin
        mass_q <= cfg_wdata_i[MASS_W-1:0];
      end
      if (cfg_idx_i == REG_SELECT) begin
        select_q <= cfg_wdata_i[SELECT_W-1:0];
      end
      for (int k = 0; k < FILTER_SLOTS; k++) begin
        if (cfg_idx_i == CFG_IDX_W'(REG_BOUNDS0 + k)) begin
          bounds_q[k] <= cfg_wdata_i;
        end
      end
    end
  end

  assign busy = 1'b0;

  // valid bits, one per stage
  logic [PIPE_DEPTH-1:0] vld_q;
  logic                  out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], start};
    end
  end

  // raw fields travel alongside the arithmetic
  logic [PACK_W-1:0] fields_in;
  logic [PACK_W-1:0] fields_mid;
  logic [PACK_W-1:0] fields_end;

  assign fields_in = {pos_x_i, pos_y_i, pos_z_i, mom_x_i, mom_y_i, mom_z_i, part_weight_i};

  ppsf_delay #(.WIDTH(PACK_W), .DEPTH(FRONT_LAT)) u_delay_front (
    .clk_i (clk_i),
    .d_i   (fields_in),
    .q_o   (fields_mid)
  );

  ppsf_delay #(.WIDTH(PACK_W), .DEPTH(CORDIC_LAT)) u_delay_back (
    .clk_i (clk_i),
    .d_i   (fields_mid),
    .q_o   (fields_end)
  );

  // stage 1: squared magnitudes
  logic [DATA_W-1:0] abs_x, abs_y, abs_z;
  logic [SQ_W-1:0]   sqx_q, sqy_q, sqz_q;

  assign abs_x = mom_x_i[DATA_W-1] ? -mom_x_i : mom_x_i;
  assign abs_y = mom_y_i[DATA_W-1] ? -mom_y_i : mom_y_i;
  assign abs_z = mom_z_i[DATA_W-1] ? -mom_z_i : mom_z_i;

  always_ff @(posedge clk_i) begin
    sqx_q <= abs_x * abs_x;
    sqy_q <= abs_y * abs_y;
    sqz_q <= abs_z * abs_z;
  end

  // stages 2 and 3: sums
  logic [SQ_W-1:0] pxy2_q, sqz2_q, pxy3_q, p2_q, gsum_q;

  always_ff @(posedge clk_i) begin
    pxy2_q <= sqx_q + sqy_q;
    sqz2_q <= sqz_q;
    pxy3_q <= pxy2_q;
    p2_q   <= pxy2_q + sqz2_q;
    gsum_q <= pxy2_q + sqz2_q + ONE_2F;
  end

  logic [DATA_W-1:0] ptot_root, gamma_root, rxy_root;

  ppsf_isqrt u_isqrt_ptot (
    .clk_i  (clk_i),
    .rad_i  (p2_q),
    .root_o (ptot_root)
  );

  ppsf_isqrt u_isqrt_gamma (
    .clk_i  (clk_i),
    .rad_i  (gsum_q),
    .root_o (gamma_root)
  );

  ppsf_isqrt u_isqrt_rxy (
    .clk_i  (clk_i),
    .rad_i  (pxy3_q),
    .root_o (rxy_root)
  );

  // kinetic energy: subtract rest term, scale by mass, saturate
  logic [DATA_W-1:0] ptsat_q, gm1_q, ekin_q;
  logic [PROD_W-1:0] prod_q;
  logic [PROD_W-1:0] ekin_full;

  assign ekin_full = prod_q >> FRAC_BITS;

  always_ff @(posedge clk_i) begin
    ptsat_q <= ptot_root[DATA_W-1] ? SAT_POS : ptot_root;
    gm1_q   <= gamma_root - ONE_F;
    prod_q  <= mass_q * gm1_q;
    ekin_q  <= (ekin_full > PROD_W'(SAT_POS)) ? SAT_POS : ekin_full[DATA_W-1:0];
  end

  logic [DATA_W-1:0] ptot_end, ekin_end;

  ppsf_delay #(.WIDTH(DATA_W), .DEPTH(CORDIC_LAT - 1)) u_delay_ptot (
    .clk_i (clk_i),
    .d_i   (ptsat_q),
    .q_o   (ptot_end)
  );

  ppsf_delay #(.WIDTH(DATA_W), .DEPTH(CORDIC_LAT - 3)) u_delay_ekin (
    .clk_i (clk_i),
    .d_i   (ekin_q),
    .q_o   (ekin_end)
  );

  // angles
  logic [DATA_W-1:0]        mid_mom_x, mid_mom_y, mid_mom_z;
  logic signed [DATA_W-1:0] azimuth, polar;

  assign mid_mom_x = fields_mid[3*DATA_W +: DATA_W];
  assign mid_mom_y = fields_mid[2*DATA_W +: DATA_W];
  assign mid_mom_z = fields_mid[1*DATA_W +: DATA_W];

  ppsf_cordic #(.FRAC_BITS(FRAC_BITS)) u_cordic_azimuth (
    .clk_i   (clk_i),
    .x_i     ($signed({mid_mom_x[DATA_W-1], mid_mom_x})),
    .y_i     ($signed(mid_mom_y)),
    .angle_o (azimuth)
  );

  ppsf_cordic #(.FRAC_BITS(FRAC_BITS)) u_cordic_polar (
    .clk_i   (clk_i),
    .x_i     ($signed({1'b0, rxy_root})),
    .y_i     ($signed(mid_mom_z)),
    .angle_o (polar)
  );

  // slot compare
  logic pass;

  always_comb begin
    logic [SLOT_FIELD_W-1:0]  sel;
    logic                     known;
    logic signed [DATA_W-1:0] val;
    logic signed [DATA_W-1:0] lo;
    logic signed [DATA_W-1:0] hi;
    pass = 1'b1;
    for (int k = 0; k < FILTER_SLOTS; k++) begin
      sel   = select_q[k*SLOT_FIELD_W +: SLOT_FIELD_W];
      known = 1'b1;
      val   = '0;
      case (qty_e'(sel[3:0]))
        QTY_POS_X:   val = fields_end[6*DATA_W +: DATA_W];
        QTY_POS_Y:   val = fields_end[5*DATA_W +: DATA_W];
        QTY_POS_Z:   val = fields_end[4*DATA_W +: DATA_W];
        QTY_MOM_X:   val = fields_end[3*DATA_W +: DATA_W];
        QTY_MOM_Y:   val = fields_end[2*DATA_W +: DATA_W];
        QTY_MOM_Z:   val = fields_end[1*DATA_W +: DATA_W];
        QTY_MOM_TOT: val = ptot_end;
        QTY_KIN_EN:  val = ekin_end;
        QTY_AZIMUTH: val = azimuth;
        QTY_POLAR:   val = polar;
        default:     known = 1'b0;
      endcase
      lo = bounds_q[k][DATA_W-1:0];
      hi = bounds_q[k][2*DATA_W-1:DATA_W];
      // unknown quantity codes always hold
      if (sel[SLOT_FIELD_W-1] && known && (val < lo || val > hi)) begin
        pass = 1'b0;
      end
    end
  end

  // output register
  logic [PACK_W-1:0] out_fields_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= vld_q[PIPE_DEPTH-1] && pass;
    end
  end

  always_ff @(posedge clk_i) begin
    out_fields_q <= fields_end;
  end

  assign out_valid_o  = out_valid_q;
  assign out_pos_x_o  = out_fields_q[6*DATA_W +: DATA_W];
  assign out_pos_y_o  = out_fields_q[5*DATA_W +: DATA_W];
  assign out_pos_z_o  = out_fields_q[4*DATA_W +: DATA_W];
  assign out_mom_x_o  = out_fields_q[3*DATA_W +: DATA_W];
  assign out_mom_y_o  = out_fields_q[2*DATA_W +: DATA_W];
  assign out_mom_z_o  = out_fields_q[1*DATA_W +: DATA_W];
  assign out_weight_o = out_fields_q[0 +: DATA_W];

endmodule
